// ===== hdl/bmroc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmroc_pkg: shared types and constants of the mask run open/close unit
// Segment record, queue push bundle, queue status and register codes.
// ----------------------------------------------------------------------------
package bmroc_pkg;

    localparam int unsigned LEN_W      = 21;   // segment length field
    localparam int unsigned LIMIT_W    = 16;   // limit register
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;   // widest register

    localparam int unsigned LEN_MAX        = (2 ** LEN_W) - 1;
    localparam int unsigned TRACK_BITS_DEF = 1048576;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    // filter modes
    localparam logic MODE_CLOSE = 1'b0;
    localparam logic MODE_OPEN  = 1'b1;

    // output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned LVL_W      = 3;

    typedef struct packed {
        logic             value;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_seg;

    // up to two segments per input bit; push_b implies push_a
    typedef struct packed {
        logic push_a;
        logic push_b;
        t_seg seg_a;
        t_seg seg_b;
    } t_push;

    typedef struct packed {
        logic [LVL_W-1:0] level;
    } t_fifo_stat;

endpackage

// ===== hdl/bmroc_in_if.sv =====
// ----------------------------------------------------------------------------
// bmroc_in_if: mask bit channel
// One beat carries one mask bit and the end-of-track flag.
// ----------------------------------------------------------------------------
interface bmroc_in_if;
    logic valid;
    logic ready;
    logic mask_bit;
    logic last_bit;

    modport source (output valid, output mask_bit, output last_bit, input ready);
    modport sink   (input valid, input mask_bit, input last_bit, output ready);
endinterface

// ===== hdl/bmroc_out_if.sv =====
// ----------------------------------------------------------------------------
// bmroc_out_if: segment channel
// One beat carries one run segment: value, length and last flag.
// ----------------------------------------------------------------------------
interface bmroc_out_if;
    import bmroc_pkg::*;
    logic             valid;
    logic             ready;
    logic             seg_value;
    logic [LEN_W-1:0] seg_length;
    logic             seg_last;

    modport source (output valid, output seg_value, output seg_length, output seg_last,
                    input ready);
    modport sink   (input valid, input seg_value, input seg_length, input seg_last,
                    output ready);
endinterface

// ===== hdl/bmroc_core.sv =====
// ----------------------------------------------------------------------------
// bmroc_core: run tracker and filter decision
// Holds the pending run and emits up to two segments per accepted bit.
// ----------------------------------------------------------------------------
module bmroc_core import bmroc_pkg::*; #(
    parameter int unsigned TRACK_BITS = TRACK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_mask_bit,
    input  logic               i_last_bit,
    input  logic               i_mode,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_push              o_push
);

    localparam logic [LEN_W-1:0] RUN_CAP =
        (TRACK_BITS < LEN_MAX) ? LEN_W'(TRACK_BITS) : LEN_W'(LEN_MAX);

    logic             r_run_value, n_run_value;
    logic [LEN_W-1:0] r_run_count, n_run_count;
    logic             r_seen_one,  n_seen_one;
    logic             r_run_open,  n_run_open;
    logic             r_run_long,  n_run_long;

    logic chg, cap, lim_hit, judged;
    t_seg seg_split, seg_end;

    always_comb begin
        lim_hit = (r_run_count <= {{(LEN_W-LIMIT_W){1'b0}}, i_limit});
        judged  = r_run_value;
        if (!r_run_long) begin
            case (i_mode)
                MODE_CLOSE: begin
                    if (!r_run_value && r_seen_one && lim_hit) judged = 1'b1;
                end
                MODE_OPEN: begin
                    if (r_run_value && lim_hit) judged = 1'b0;
                end
                default: judged = r_run_value;
            endcase
        end

        chg = r_run_open && (i_mask_bit != r_run_value);
        cap = r_run_open && !chg && (r_run_count >= RUN_CAP);

        seg_split.value  = chg ? judged : r_run_value;
        seg_split.length = r_run_count;
        seg_split.last   = 1'b0;

        n_seen_one  = r_seen_one | i_mask_bit;
        n_run_open  = 1'b1;
        if (chg || !r_run_open) begin
            n_run_value = i_mask_bit;
            n_run_count = LEN_W'(1);
            n_run_long  = 1'b0;
        end else if (cap) begin
            n_run_value = r_run_value;
            n_run_count = LEN_W'(1);
            n_run_long  = 1'b1;
        end else begin
            n_run_value = r_run_value;
            n_run_count = r_run_count + LEN_W'(1);
            n_run_long  = r_run_long;
        end

        seg_end.value  = n_run_value;
        seg_end.length = n_run_count;
        seg_end.last   = 1'b1;

        if (i_last_bit) begin
            n_run_value = 1'b0;
            n_run_count = '0;
            n_seen_one  = 1'b0;
            n_run_open  = 1'b0;
            n_run_long  = 1'b0;
        end

        // pack so that a lone segment always sits in slot a
        if (chg || cap) begin
            o_push.push_a = i_fire;
            o_push.push_b = i_fire && i_last_bit;
            o_push.seg_a  = seg_split;
        end else begin
            o_push.push_a = i_fire && i_last_bit;
            o_push.push_b = 1'b0;
            o_push.seg_a  = seg_end;
        end
        o_push.seg_b = seg_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value <= 1'b0;
            r_run_count <= '0;
            r_seen_one  <= 1'b0;
            r_run_open  <= 1'b0;
            r_run_long  <= 1'b0;
        end else if (i_fire) begin
            r_run_value <= n_run_value;
            r_run_count <= n_run_count;
            r_seen_one  <= n_seen_one;
            r_run_open  <= n_run_open;
            r_run_long  <= n_run_long;
        end
    end

endmodule

// ===== hdl/bmroc_fifo.sv =====
// ----------------------------------------------------------------------------
// bmroc_fifo: segment output queue
// Four entries, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module bmroc_fifo import bmroc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop,
    output t_seg       o_head,
    output t_fifo_stat o_stat
);

    t_seg               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, n_wp;
    logic [FIFO_AW-1:0] r_rp, n_rp;
    logic [LVL_W-1:0]   r_level, n_level;

    always_comb begin
        n_wp    = r_wp + FIFO_AW'(i_push.push_a) + FIFO_AW'(i_push.push_b);
        n_rp    = r_rp + FIFO_AW'(i_pop);
        n_level = r_level + LVL_W'(i_push.push_a) + LVL_W'(i_push.push_b)
                - LVL_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) r_mem[r_wp] <= i_push.seg_a;
        if (i_push.push_b) r_mem[r_wp + FIFO_AW'(1)] <= i_push.seg_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.level = r_level;

endmodule

// ===== hdl/bit_mask_run_open_close_unit.sv =====
// ----------------------------------------------------------------------------
// bit_mask_run_open_close_unit: 1-D open/close filter on a weak-bit mask
// Takes mask bits, emits filtered run segments (value, length, last).
// ----------------------------------------------------------------------------
// Takes one mask bit per beat and can accept a bit every clock cycle. Each
// bit produces zero, one or two segment beats into the queue: a segment when
// the pending run ends (value change) or reaches the run cap, and the final
// segment when the bit carries the last flag. Segments go through a four-entry
// output queue; the input stalls whenever fewer than two entries are free, so
// the sustained rate is one bit per cycle while the sink takes a segment every
// cycle, and is bounded by the segment drain rate of one per cycle otherwise.
// mode 0 (close) fills zero gaps between ones of length <= limit; mode 1
// (open) clears one runs of length <= limit that end in a zero, including a
// run starting at bit 0. The run holding the last bit is passed unchanged.
// Runs longer than the cap (TRACK_BITS, clipped to 2^21-1) are split and the
// remainder kept unchanged. A run is judged with the register values present
// in the cycle its ending bit is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module bit_mask_run_open_close_unit import bmroc_pkg::*; #(
    parameter int unsigned TRACK_BITS = TRACK_BITS_DEF   // 8 .. 16777216
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmroc_in_if.sink              i_bits,
    bmroc_out_if.source           o_segs,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic               r_mode;
    logic [LIMIT_W-1:0] r_limit;

    logic       fire;      // input beat taken
    logic       pop;       // output beat taken
    t_push      push;
    t_seg       head;
    t_fifo_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_CLOSE;
            r_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

    // room for the worst case of two segments from the next bit
    assign i_bits.ready = (stat.level <= LVL_W'(FIFO_DEPTH - 2));
    assign fire         = i_bits.valid && i_bits.ready;
    assign pop          = o_segs.valid && o_segs.ready;

    bmroc_core #(
        .TRACK_BITS (TRACK_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_mask_bit (i_bits.mask_bit),
        .i_last_bit (i_bits.last_bit),
        .i_mode     (r_mode),
        .i_limit    (r_limit),
        .o_push     (push)
    );

    bmroc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    assign o_segs.valid      = (stat.level != '0);
    assign o_segs.seg_value  = head.value;
    assign o_segs.seg_length = head.length;
    assign o_segs.seg_last   = head.last;

`ifndef SYNTHESIS
    // queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.level <= LVL_W'(FIFO_DEPTH))
        else $error("segment queue level out of range");

    // a last bit always leaves at least one segment queued
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_bits.last_bit) |=> (stat.level != '0))
        else $error("last bit produced no segment");

    // every emitted segment has nonzero length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_segs.valid |-> (o_segs.seg_length != '0))
        else $error("zero-length segment");

    // a second segment is only pushed together with a first one
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push_b |-> (push.push_a && push.seg_b.last))
        else $error("segment push out of order");
`endif

endmodule
